// ----- src/mksf_pkg.sv -----
// ============================================================================
// mksf_pkg: shared types and constants of the masked k-mer seed filter
// Holds the default geometry, the mode codes, the queue depth and the
// control word that travels with every base from front to back.
// ============================================================================
package mksf_pkg;

  // Default geometry: window length in bases and number of segments.
  localparam int KMER_BASES_DEF    = 12;
  localparam int SEGMENT_COUNT_DEF = 6;

  // Entries in the queue between front and back (a power of two).
  localparam int QUEUE_DEPTH = 4;

  // A masked k-mer is low complexity when one base value fills all positions
  // but at most this many.
  localparam int LOW_COMPLEXITY_MARGIN = 2;

  // Hit threshold after reset.
  localparam logic [1:0] THRESHOLD_RESET = 2'd2;

  // Mode codes of the input item.
  localparam logic MODE_INDEX = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Control word of one base as it moves through the queue.
  typedef struct packed {
    logic mode;    // index or query
    logic first;   // starts a new sequence or read
    logic last;    // final base of the sequence or read
    logic active;  // the window is full at this base
  } ctrl_t;

endpackage

// ----- src/mksf_front.sv -----
// ============================================================================
// mksf_front: base intake and masked k-mer classification
// Keeps the rolling window, forms the masked k-mer of every segment and
// decides which of them pass the low-complexity filter.
// ============================================================================
module mksf_front #(
  parameter int KMER_BASES    = mksf_pkg::KMER_BASES_DEF,
  parameter int SEGMENT_COUNT = mksf_pkg::SEGMENT_COUNT_DEF,
  localparam int SEG_BASES    = KMER_BASES / SEGMENT_COUNT,
  localparam int SEG_W        = 2 * SEG_BASES,
  localparam int MASKED_BASES = KMER_BASES - SEG_BASES,
  localparam int MASKED_BITS  = 2 * MASKED_BASES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_mode,
  input  logic [1:0]                           in_base,
  input  logic                                 in_first_base,
  input  logic                                 in_last_base,
  input  logic                                 q_full,
  input  logic                                 clear_busy,
  output logic                                 push,
  output mksf_pkg::ctrl_t                      push_ctrl,
  output logic [SEGMENT_COUNT-1:0]             push_wmask,
  output logic [SEGMENT_COUNT*MASKED_BITS-1:0] push_keys
);

  localparam int WIN_BITS = 2 * KMER_BASES;
  localparam int CNT_W    = $clog2(KMER_BASES + 1);

  logic [WIN_BITS-1:0] window_r;
  logic [CNT_W-1:0]    seen_r;
  logic [WIN_BITS-1:0] win_base;
  logic [WIN_BITS-1:0] win_nxt;
  logic [CNT_W-1:0]    seen_base;
  logic [CNT_W-1:0]    seen_nxt;
  logic                active;
  logic [KMER_BASES-1:0] base_eq [4];
  logic [CNT_W-1:0]      full_cnt [4];
  logic [SEGMENT_COUNT-1:0] complex_ok;

  assign in_stall = q_full || clear_busy;
  assign push     = in_valid && !in_stall;

  // A first base starts from an empty window.
  assign win_base  = in_first_base ? '0 : window_r;
  assign win_nxt   = {win_base[WIN_BITS-3:0], in_base};
  assign seen_base = in_first_base ? '0 : seen_r;
  assign seen_nxt  = (seen_base < CNT_W'(KMER_BASES)) ? seen_base + CNT_W'(1) : seen_base;
  assign active    = (seen_nxt == CNT_W'(KMER_BASES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      seen_r   <= '0;
    end else if (push) begin
      window_r <= win_nxt;
      seen_r   <= seen_nxt;
    end
  end

  // Per base value, which window positions hold it.
  always_comb begin
    for (int v = 0; v < 4; v++) begin
      for (int i = 0; i < KMER_BASES; i++) begin
        base_eq[v][i] = (win_nxt[2*i +: 2] == 2'(v));
      end
      full_cnt[v] = CNT_W'($countones(base_eq[v]));
    end
  end

  for (genvar j = 0; j < SEGMENT_COUNT; j++) begin : g_seg
    localparam int LOW_BITS = SEG_W * j;
    logic [WIN_BITS-1:0] low_mask;
    logic [WIN_BITS-1:0] kept_bits;
    logic [3:0]          value_ok;

    // Drop segment j: bases below it stay, bases above it move down.
    assign low_mask  = (WIN_BITS'(1) << LOW_BITS) - WIN_BITS'(1);
    assign kept_bits = (win_nxt & low_mask) | ((win_nxt >> SEG_W) & ~low_mask);
    assign push_keys[j*MASKED_BITS +: MASKED_BITS] = kept_bits[MASKED_BITS-1:0];

    // Counts of the masked k-mer are those of the window less the dropped segment.
    for (genvar v = 0; v < 4; v++) begin : g_val
      logic [CNT_W-1:0] seg_cnt;
      logic [CNT_W-1:0] kept_cnt;
      assign seg_cnt  = CNT_W'($countones(base_eq[v][j*SEG_BASES +: SEG_BASES]));
      assign kept_cnt = full_cnt[v] - seg_cnt;
      assign value_ok[v] = ({1'b0, kept_cnt} + (CNT_W+1)'(mksf_pkg::LOW_COMPLEXITY_MARGIN))
                           < (CNT_W+1)'(MASKED_BASES);
    end

    assign complex_ok[j] = &value_ok;
    assign push_wmask[j] = active && (in_mode == mksf_pkg::MODE_INDEX) && complex_ok[j];
  end

  always_comb begin
    push_ctrl.mode   = in_mode;
    push_ctrl.first  = in_first_base;
    push_ctrl.last   = in_last_base;
    push_ctrl.active = active;
  end

endmodule

// ----- src/mksf_queue.sv -----
// ============================================================================
// mksf_queue: short queue between front and back
// A small register queue that decouples base intake from table access.
// ============================================================================
module mksf_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = $clog2(mksf_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(mksf_pkg::QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] slot_r [mksf_pkg::QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;

  assign full     = (count_r == CW'(mksf_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/mksf_back.sv -----
// ============================================================================
// mksf_back: segment tables, hit counting and result register
// Owns one presence memory per segment, clears them after reset, sets or
// tests the masked k-mers of each base and delivers the per-read result.
// ============================================================================
module mksf_back #(
  parameter int KMER_BASES    = mksf_pkg::KMER_BASES_DEF,
  parameter int SEGMENT_COUNT = mksf_pkg::SEGMENT_COUNT_DEF,
  localparam int SEG_BASES    = KMER_BASES / SEGMENT_COUNT,
  localparam int MASKED_BITS  = 2 * (KMER_BASES - SEG_BASES)
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  output logic                                 pop,
  input  mksf_pkg::ctrl_t                      pop_ctrl,
  input  logic [SEGMENT_COUNT-1:0]             pop_wmask,
  input  logic [SEGMENT_COUNT*MASKED_BITS-1:0] pop_keys,
  input  logic [1:0]                           threshold,
  output logic                                 clear_busy,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_read_selected,
  output logic [1:0]                           out_hit_count
);

  localparam int TABLE_DEPTH = 1 << MASKED_BITS;

  logic                     clear_busy_r;
  logic [MASKED_BITS-1:0]   clr_addr_r;
  logic                     a_valid_r;
  mksf_pkg::ctrl_t          a_ctrl_r;
  logic [SEGMENT_COUNT-1:0] rd_hit_r;
  logic [1:0]               hits_r;
  logic                     out_valid_r;
  logic                     out_sel_r;
  logic [1:0]               out_cnt_r;

  logic       a_needs_out;
  logic       a_go;
  logic       retire;
  logic       rd_en;
  logic [1:0] hits_base;
  logic [1:0] hits_nxt;

  assign clear_busy        = clear_busy_r;
  assign out_valid         = out_valid_r;
  assign out_read_selected = out_sel_r;
  assign out_hit_count     = out_cnt_r;

  // The access stage holds only when its result cannot enter the output register.
  assign a_needs_out = (a_ctrl_r.mode == mksf_pkg::MODE_QUERY) && a_ctrl_r.last;
  assign a_go        = !a_valid_r || !(a_needs_out && out_valid_r && out_stall);
  assign pop         = !q_empty && a_go && !clear_busy_r;
  assign retire      = a_valid_r && a_go;
  assign rd_en       = pop && pop_ctrl.active && (pop_ctrl.mode == mksf_pkg::MODE_QUERY);

  for (genvar j = 0; j < SEGMENT_COUNT; j++) begin : g_table
    logic                   table_mem [TABLE_DEPTH];
    logic [MASKED_BITS-1:0] key;

    assign key = pop_keys[j*MASKED_BITS +: MASKED_BITS];

    always_ff @(posedge clk) begin
      if (clear_busy_r) begin
        table_mem[clr_addr_r] <= 1'b0;
      end else if (pop && pop_wmask[j]) begin
        table_mem[key] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r[j] <= table_mem[key];
      end
    end
  end

  always_comb begin
    hits_base = a_ctrl_r.first ? 2'd0 : hits_r;
    hits_nxt  = hits_base;
    if (a_ctrl_r.active && (a_ctrl_r.mode == mksf_pkg::MODE_QUERY) && (|rd_hit_r)
        && (hits_base < threshold)) begin
      hits_nxt = hits_base + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_busy_r <= 1'b1;
      clr_addr_r   <= '0;
      a_valid_r    <= 1'b0;
      hits_r       <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clear_busy_r) begin
        clr_addr_r <= clr_addr_r + MASKED_BITS'(1);
        if (clr_addr_r == '1) begin
          clear_busy_r <= 1'b0;
        end
      end
      if (a_go) begin
        a_valid_r <= pop;
      end
      if (retire) begin
        hits_r <= hits_nxt;
      end
      if (retire && a_needs_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_ctrl_r <= pop_ctrl;
    end
    if (retire && a_needs_out) begin
      out_sel_r <= (hits_nxt >= threshold);
      out_cnt_r <= hits_nxt;
    end
  end

endmodule

// ----- src/masked_kmer_seed_filter.sv -----
// ============================================================================
// masked_kmer_seed_filter: spaced-seed k-mer presence filter for reads
// Indexes reference bases into per-segment presence tables and counts how
// many window positions of each query read hit those tables.
// ============================================================================
// The block takes one 2-bit base per cycle, back to back, while in_stall is
// low, on the in_ channel and keeps a rolling window of KMER_BASES bases. Once
// the window is full, every base forms SEGMENT_COUNT masked k-mers, each with
// one segment of KMER_BASES/SEGMENT_COUNT bases dropped. An index base sets
// the presence bit of every masked k-mer that is not low complexity; a query
// base counts one hit when any segment table holds its masked k-mer. A query
// base marked as last delivers one result transfer on the out_ channel; index
// bases deliver none. A base passes the front in its accept cycle, waits in a
// four-entry queue, reads the tables into the access stage and lands in the
// output register. The sustained rate of one base per cycle without stalls is
// set by the single port of each segment memory, which serves one set or one
// test per base. After reset the tables are swept clear, one entry per cycle
// in all segments together, over the 4^(KMER_BASES - KMER_BASES/SEGMENT_COUNT)
// entries of each table (1048576 at the default geometry); in_stall stays high
// during the sweep. The user must write hit_threshold through cfg_wr_en and
// cfg_wr_data only while the block is idle; the block does not enforce it.
// ============================================================================
module masked_kmer_seed_filter #(
  parameter int KMER_BASES    = mksf_pkg::KMER_BASES_DEF,
  parameter int SEGMENT_COUNT = mksf_pkg::SEGMENT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [1:0] in_base,
  input  logic       in_first_base,
  input  logic       in_last_base,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_read_selected,
  output logic [1:0] out_hit_count,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data
);

  localparam int SEG_BASES   = KMER_BASES / SEGMENT_COUNT;
  localparam int MASKED_BITS = 2 * (KMER_BASES - SEG_BASES);
  localparam int KEYS_W      = SEGMENT_COUNT * MASKED_BITS;
  localparam int ENTRY_W     = $bits(mksf_pkg::ctrl_t) + SEGMENT_COUNT + KEYS_W;

  // Hit threshold register; a zero threshold selects every read.
  logic [1:0] threshold_r;

  logic                     push;
  mksf_pkg::ctrl_t          push_ctrl;
  logic [SEGMENT_COUNT-1:0] push_wmask;
  logic [KEYS_W-1:0]        push_keys;
  logic                     q_full;
  logic                     q_empty;
  logic                     pop;
  logic [ENTRY_W-1:0]       pop_data;
  mksf_pkg::ctrl_t          pop_ctrl;
  logic [SEGMENT_COUNT-1:0] pop_wmask;
  logic [KEYS_W-1:0]        pop_keys;
  logic                     clear_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= mksf_pkg::THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  // The front classifies each base: window update, masked keys and the
  // low-complexity decision that turns into a per-segment write mask.
  mksf_front #(
    .KMER_BASES    (KMER_BASES),
    .SEGMENT_COUNT (SEGMENT_COUNT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_base       (in_base),
    .in_first_base (in_first_base),
    .in_last_base  (in_last_base),
    .q_full        (q_full),
    .clear_busy    (clear_busy),
    .push          (push),
    .push_ctrl     (push_ctrl),
    .push_wmask    (push_wmask),
    .push_keys     (push_keys)
  );

  // The queue lets the front keep taking bases while the result side stalls.
  mksf_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctrl, push_wmask, push_keys}),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  assign pop_ctrl  = pop_data[ENTRY_W-1 -: $bits(mksf_pkg::ctrl_t)];
  assign pop_wmask = pop_data[KEYS_W +: SEGMENT_COUNT];
  assign pop_keys  = pop_data[KEYS_W-1:0];

  // The back owns the tables. Each entry is handled in order, so a query base
  // always sees every index base that came before it.
  mksf_back #(
    .KMER_BASES    (KMER_BASES),
    .SEGMENT_COUNT (SEGMENT_COUNT)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .pop               (pop),
    .pop_ctrl          (pop_ctrl),
    .pop_wmask         (pop_wmask),
    .pop_keys          (pop_keys),
    .threshold         (threshold_r),
    .clear_busy        (clear_busy),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_selected (out_read_selected),
    .out_hit_count     (out_hit_count)
  );

endmodule

// ----- tb/masked_kmer_seed_filter_test.sv -----
// ============================================================================
// masked_kmer_seed_filter_test: self-checking testbench of the seed filter
// Builds reference sequences into the segment tables and streams query reads
// against them. A predictor inside the bench tracks the window, the hit count
// and its own copy of the tables. Every read verdict is checked field by field.
// ============================================================================
module masked_kmer_seed_filter_test;

  // Geometry of the block under test, derived the same way the block does.
  localparam int K             = mksf_pkg::KMER_BASES_DEF;
  localparam int SEGS          = mksf_pkg::SEGMENT_COUNT_DEF;
  localparam int SEG_W         = 2 * (K / SEGS);
  localparam int MASKED_BASES  = K - K / SEGS;
  localparam int MASKED_BITS   = 2 * MASKED_BASES;

  // The tables are swept clear after reset, one entry per cycle, with
  // in_stall held high. The cycle limit has to cover that sweep first.
  localparam int SWEEP_CYCLES  = 1 << MASKED_BITS;
  localparam int LIMIT_CYCLES  = SWEEP_CYCLES + 1_000_000;

  // Cycles to let an index base that is still in flight finish its table
  // write before the threshold is changed, and the quiet time at the end.
  localparam int SETTLE_CYCLES = mksf_pkg::QUEUE_DEPTH + 8;
  localparam int DRAIN_CYCLES  = mksf_pkg::QUEUE_DEPTH + 16;

  localparam int RANDOM_ITEMS  = 1650;
  localparam int PHASE_ITEMS   = 300;
  localparam int POOL_LIMIT    = 800;

  typedef enum logic {ROW_BASE, ROW_THRESHOLD} row_kind_t;

  // One row of the directed stimulus: either a base transfer or a write of
  // the threshold register. A row may carry its verdict typed in by hand.
  typedef struct {
    row_kind_t  kind;
    logic [1:0] thr;
    logic       mode;
    logic [1:0] base;
    logic       is_first;
    logic       is_last;
    bit         typed;
    logic       typed_sel;
    logic [1:0] typed_cnt;
  } stim_row_t;

  // What the block reports at the last base of a query read.
  typedef struct {
    logic       selected;
    logic [1:0] count;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_mode = mksf_pkg::MODE_INDEX;
  logic [1:0] in_base = 2'd0;
  logic       in_first_base = 1'b0;
  logic       in_last_base = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_read_selected;
  logic [1:0] out_hit_count;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = 2'd0;

  masked_kmer_seed_filter DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_base           (in_base),
    .in_first_base     (in_first_base),
    .in_last_base      (in_last_base),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_selected (out_read_selected),
    .out_hit_count     (out_hit_count),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the rolling window, how many bases it holds, the hits
  // of the current read, the threshold and a sparse copy of the tables.
  // --------------------------------------------------------------------------
  logic [2*K-1:0] window_bases = '0;
  int             window_fill = 0;
  int             read_hit_count = 0;
  logic [1:0]     threshold = mksf_pkg::THRESHOLD_RESET;
  bit             seed_bits [int unsigned];

  verdict_t       pending_verdicts [$];
  logic [1:0]     reference_pool [$];
  stim_row_t      directed_rows [$];

  int  err_count = 0;
  int  random_sent = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  valid_held = 0;

  // Masked k-mer of segment seg: the bases below the dropped segment stay in
  // place and the bases above it move down by one segment.
  function automatic logic [MASKED_BITS-1:0] drop_seg_key(logic [2*K-1:0] kmer, int seg);
    logic [2*K-1:0] low_mask;
    logic [2*K-1:0] joined;
    low_mask = (2*K)'(1);
    low_mask = (low_mask << (SEG_W * seg)) - (2*K)'(1);
    joined = (kmer & low_mask) | ((kmer >> SEG_W) & ~low_mask);
    return joined[MASKED_BITS-1:0];
  endfunction

  // A masked k-mer is worth indexing only when no single base value covers
  // all but at most two of its positions.
  function automatic bit varied_enough(logic [MASKED_BITS-1:0] m);
    int tally [4];
    int most;
    most = 0;
    foreach (tally[v]) tally[v] = 0;
    for (int i = 0; i < MASKED_BASES; i++) tally[m[2*i +: 2]]++;
    foreach (tally[v]) if (tally[v] > most) most = tally[v];
    return (most + mksf_pkg::LOW_COMPLEXITY_MARGIN) < MASKED_BASES;
  endfunction

  function automatic int unsigned seed_slot(logic [MASKED_BITS-1:0] m, int seg);
    return (unsigned'(seg) << MASKED_BITS) | 32'(m);
  endfunction

  // Advances the predictor by one accepted base. Returns 1 when the base
  // closes a query read, with the verdict the block should report.
  function automatic bit predict_verdict(logic mode, logic [1:0] base, logic is_first,
                                         logic is_last, output verdict_t v);
    logic [MASKED_BITS-1:0] m;
    bit hit;
    hit = 0;
    if (is_first) begin
      window_bases = '0;
      window_fill = 0;
      read_hit_count = 0;
    end
    window_bases = {window_bases[2*K-3:0], base};
    if (window_fill < K) window_fill++;
    if (window_fill >= K) begin
      for (int seg = 0; seg < SEGS; seg++) begin
        m = drop_seg_key(window_bases, seg);
        if (mode == mksf_pkg::MODE_INDEX) begin
          if (varied_enough(m)) seed_bits[seed_slot(m, seg)] = 1'b1;
        end else if (seed_bits.exists(seed_slot(m, seg))) begin
          hit = 1;
        end
      end
      // The count saturates at the threshold, so a zero threshold keeps it
      // at zero while the read is still selected.
      if (hit && read_hit_count < int'(threshold)) read_hit_count++;
    end
    v.selected = (read_hit_count >= int'(threshold));
    v.count = read_hit_count[1:0];
    return (mode == mksf_pkg::MODE_QUERY) && is_last;
  endfunction

  // Sender gaps: mostly back to back or short, now and then a long pause,
  // and whole stretches of reads without any gap.
  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (((random_sent / 100) % 6) == 5) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int receiver_stall();
    int r;
    r = $urandom_range(0, 99);
    if (((cycle_count / 2000) % 5) == 0) return 0;
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Drives one base and holds it until the block takes the transfer. The
  // predictor runs at the accepting edge, so the expectation is queued well
  // before the verdict can come out.
  task automatic send_base(logic mode, logic [1:0] base, logic is_first, logic is_last,
                           bit typed, logic typed_sel, logic [1:0] typed_cnt);
    verdict_t v;
    int gap;
    in_valid <= 1'b1;
    in_mode <= mode;
    in_base <= base;
    in_first_base <= is_first;
    in_last_base <= is_last;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (predict_verdict(mode, base, is_first, is_last, v)) begin
      if (typed) begin
        v.selected = typed_sel;
        v.count = typed_cnt;
      end
      pending_verdicts = {pending_verdicts, v};
    end
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      valid_held = 0;
      repeat (gap) @(posedge clk);
    end else begin
      valid_held = 1;
    end
  endtask

  // The threshold is only changed while the block is idle: every verdict is
  // in, and an index base that makes no verdict has had time to retire.
  // Waiting on the verdicts also makes the sender pause for the receiver.
  task automatic set_threshold(logic [1:0] value);
    if (valid_held) begin
      in_valid <= 1'b0;
      valid_held = 0;
    end
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold = value;
  endtask

  // Sends one sequence or read. Most go out well formed; a few lose their
  // first or last marker, switch mode partway, or carry a stray marker.
  task automatic send_sequence(logic mode, logic [1:0] bases [$]);
    bit drop_first;
    bit drop_last;
    bit flip;
    int flip_at;
    logic m;
    logic f;
    logic l;
    drop_first = ($urandom_range(0, 99) < 8);
    drop_last = ($urandom_range(0, 99) < 5);
    flip = ($urandom_range(0, 99) < 6);
    flip_at = $urandom_range(0, bases.size() - 1);
    m = mode;
    foreach (bases[i]) begin
      if (flip && i == flip_at) m = ~m;
      f = (i == 0) ? !drop_first : ($urandom_range(0, 199) == 0);
      l = (i == bases.size() - 1) ? !drop_last : ($urandom_range(0, 199) == 0);
      send_base(m, bases[i], f, l, 0, 1'b0, 2'd0);
      random_sent++;
    end
  endtask

  task automatic add_row(row_kind_t kind, logic [1:0] thr, logic mode, logic [1:0] base,
                         logic is_first, logic is_last, bit typed, logic typed_sel,
                         logic [1:0] typed_cnt);
    stim_row_t row;
    row.kind = kind;
    row.thr = thr;
    row.mode = mode;
    row.base = base;
    row.is_first = is_first;
    row.is_last = is_last;
    row.typed = typed;
    row.typed_sel = typed_sel;
    row.typed_cnt = typed_cnt;
    directed_rows = {directed_rows, row};
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall, and a check of every result transfer against the
  // oldest expected verdict.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = receiver_stall();
    end
  end

  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        err_count++;
        $error("result transfer with no read outstanding: read_selected %0d hit_count %0d",
               out_read_selected, out_hit_count);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_read_selected !== want.selected) begin
          err_count++;
          $error("read_selected: expected %0d, got %0d", want.selected, out_read_selected);
        end
        if (out_hit_count !== want.count) begin
          err_count++;
          $error("hit_count: expected %0d, got %0d", want.count, out_hit_count);
        end
      end
    end
  end

  // The run cannot hang: past the limit it ends as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("masked_kmer_seed_filter_test: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [1:0] bases [$];
    logic [1:0] b;
    logic [1:0] phase_values [6];
    int r;
    int len;
    int start;
    int next_phase;
    int phase_idx;

    phase_values = '{2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3};

    // Directed part. A single-base read right after reset has no hits, so
    // it is reported as not selected with a count of zero.
    add_row(ROW_BASE, 2'd0, mksf_pkg::MODE_QUERY, 2'd3, 1'b1, 1'b1, 1, 1'b0, 2'd0);
    // An index base marked last makes no verdict.
    add_row(ROW_BASE, 2'd0, mksf_pkg::MODE_INDEX, 2'd2, 1'b1, 1'b1, 0, 1'b0, 2'd0);
    // A well-mixed reference of one window, then the same bases as a read:
    // its one full window position must hit.
    for (int i = 0; i < K; i++)
      add_row(ROW_BASE, 2'd0, mksf_pkg::MODE_INDEX, 2'((i * 3 + i / 4) % 4), i == 0,
              i == K - 1, 0, 1'b0, 2'd0);
    for (int i = 0; i < K; i++)
      add_row(ROW_BASE, 2'd0, mksf_pkg::MODE_QUERY, 2'((i * 3 + i / 4) % 4), i == 0,
              i == K - 1, 0, 1'b0, 2'd0);
    // A read whose first marker is missing carries on from the previous one.
    add_row(ROW_BASE, 2'd0, mksf_pkg::MODE_QUERY, 2'd1, 1'b0, 1'b1, 0, 1'b0, 2'd0);
    // With a zero threshold even a hitless read is selected, count zero.
    add_row(ROW_THRESHOLD, 2'd0, mksf_pkg::MODE_INDEX, 2'd0, 1'b0, 1'b0, 0, 1'b0, 2'd0);
    add_row(ROW_BASE, 2'd0, mksf_pkg::MODE_QUERY, 2'd0, 1'b1, 1'b1, 1, 1'b1, 2'd0);
    add_row(ROW_THRESHOLD, 2'd3, mksf_pkg::MODE_INDEX, 2'd0, 1'b0, 1'b0, 0, 1'b0, 2'd0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_THRESHOLD) begin
        set_threshold(directed_rows[i].thr);
      end else begin
        send_base(directed_rows[i].mode, directed_rows[i].base, directed_rows[i].is_first,
                  directed_rows[i].is_last, directed_rows[i].typed,
                  directed_rows[i].typed_sel, directed_rows[i].typed_cnt);
      end
    end

    // Random part. Reads are mostly taken from indexed reference with a few
    // substitutions, so hit counts climb to the threshold. The threshold
    // changes every few hundred bases, between whole sequences.
    next_phase = PHASE_ITEMS;
    phase_idx = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent >= next_phase) begin
        set_threshold(phase_values[phase_idx % 6]);
        phase_idx++;
        next_phase += PHASE_ITEMS;
      end
      bases.delete();
      r = $urandom_range(0, 99);
      if (r < 35) begin
        // Random reference sequence.
        len = $urandom_range(K, 40);
        repeat (len) bases = {bases, 2'($urandom_range(0, 3))};
      end else if (r < 45) begin
        // Low-complexity reference: one base with a few others sprinkled in.
        len = $urandom_range(K, K + 6);
        b = 2'($urandom_range(0, 3));
        repeat (len)
          bases = {bases, ($urandom_range(0, 99) < 85) ? b : 2'($urandom_range(0, 3))};
      end else if (r < 88) begin
        // Query read, usually copied from the reference with substitutions,
        // sometimes too short to fill the window.
        len = (r < 80) ? $urandom_range(K, 30) : $urandom_range(1, K - 1);
        if (reference_pool.size() >= len) begin
          start = $urandom_range(0, reference_pool.size() - len);
          for (int i = 0; i < len; i++)
            bases = {bases, ($urandom_range(0, 11) == 0) ? 2'($urandom_range(0, 3))
                                                          : reference_pool[start + i]};
        end else begin
          repeat (len) bases = {bases, 2'($urandom_range(0, 3))};
        end
      end else if (r < 94) begin
        // Unrelated query read.
        len = $urandom_range(1, 30);
        repeat (len) bases = {bases, 2'($urandom_range(0, 3))};
      end

      if (bases.size() == 0) begin
        // Noise: a few bases with every field random.
        repeat ($urandom_range(1, 4)) begin
          send_base(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 0, 1'b0, 2'd0);
          random_sent++;
        end
      end else if (r < 45) begin
        send_sequence(mksf_pkg::MODE_INDEX, bases);
        reference_pool = {reference_pool, bases};
        while (reference_pool.size() > POOL_LIMIT) void'(reference_pool.pop_front());
      end else begin
        send_sequence(mksf_pkg::MODE_QUERY, bases);
      end
    end

    if (valid_held) begin
      in_valid <= 1'b0;
      valid_held = 0;
    end
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("masked_kmer_seed_filter_test: done, clean");
    end else begin
      $display("masked_kmer_seed_filter_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/mksf_pkg.sv
src/mksf_front.sv
src/mksf_queue.sv
src/mksf_back.sv
src/masked_kmer_seed_filter.sv
tb/masked_kmer_seed_filter_test.sv
